@@ design/tlgs_pkg.sv @@
package tlgs_pkg;

    localparam int MAX_W      = 64;
    localparam int MAX_H      = 64;
    localparam int ROW_AW     = $clog2(MAX_H);
    localparam int COL_AW     = $clog2(MAX_W);
    localparam int GW_W       = 7;
    localparam int CS_W       = 6;
    localparam int CS_MAX     = 32;
    localparam int PIX_W      = 12;
    localparam int DIV_CNT_W  = $clog2(PIX_W);
    localparam int NB_CNT_W   = 4;

    typedef enum logic [1:0] {
        REQ_TOGGLE,
        REQ_CLEAR,
        REQ_STEP,
        REQ_READ
    } t_req;

    typedef struct packed {
        logic              clr;
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [ROW_AW-1:0] raddr;
        logic [MAX_W-1:0]  wdata;
    } t_mem_cmd;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] dividend;
        logic [CS_W-1:0]  divisor;
    } t_div_req;

endpackage

@@ design/toroidal_life_generation_step_top.sv @@
// Channel   Direction  Handshake                    Payload
// request   in         i_in_valid / o_in_stall      i_req_type, i_pixel_x/y, i_cell_x/y
// result    out        o_out_valid / i_out_stall    o_cell_alive, o_ignored
// config    in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A toggle makes two passes through the shared divider (x, then y); a step
// works through the grid one row at a time over the single row memory
// port pair.
// Reset (synchronous, active low) kills all cells via row valid bits.
// One request is worked at a time; a pending result waits in the output
// register while the next request is accepted.
module toroidal_life_generation_step_top import tlgs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_req_type,
    input  logic [PIX_W-1:0]  i_pixel_x,
    input  logic [PIX_W-1:0]  i_pixel_y,
    input  logic [COL_AW-1:0] i_cell_x,
    input  logic [ROW_AW-1:0] i_cell_y,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_cell_alive,
    output logic              o_ignored,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [1:0] REG_GRID_W = 2'd0;
    localparam logic [1:0] REG_GRID_H = 2'd1;
    localparam logic [1:0] REG_CELL_SZ = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOG_CHK,
        S_DIV_X,
        S_DIV_Y,
        S_TOG_RD,
        S_TOG_WR,
        S_RD_ADDR,
        S_RD_DATA,
        S_ST_LAST,
        S_ST_FIRST,
        S_ST_HOLD,
        S_ST_RN,
        S_ST_WR,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [GW_W-1:0]   r_gw;
    logic [GW_W-1:0]   r_gh;
    logic [CS_W-1:0]   r_cs;
    logic [PIX_W-1:0]  r_px;
    logic [PIX_W-1:0]  r_py;
    logic [COL_AW-1:0] r_cx;
    logic [ROW_AW-1:0] r_cy;
    logic [COL_AW-1:0] r_qx;
    logic [ROW_AW-1:0] r_qy;
    logic [ROW_AW-1:0] r_y;
    logic [MAX_W-1:0]  r_prev;
    logic [MAX_W-1:0]  r_cur;
    logic [MAX_W-1:0]  r_row0;
    logic              r_res_alive;
    logic              r_res_ign;
    logic              r_out_valid;
    logic              r_o_alive;
    logic              r_o_ign;

    logic [GW_W-1:0]   w_eff;
    logic [GW_W-1:0]   h_eff;
    logic [CS_W-1:0]   cs_eff;
    logic [PIX_W:0]    lim_x;
    logic [PIX_W:0]    lim_y;
    logic              pix_out;
    logic              in_acc;
    logic              cfg_wr;
    logic              last_row;
    t_mem_cmd          mem_cmd;
    logic [MAX_W-1:0]  mem_rdata;
    logic [MAX_W-1:0]  nxt_row;
    logic [MAX_W-1:0]  new_row;
    t_div_req          div_req;
    logic              div_done;
    logic [PIX_W-1:0]  div_quot;

    assign w_eff  = (r_gw == '0) ? GW_W'(1) : ((r_gw > GW_W'(MAX_W)) ? GW_W'(MAX_W) : r_gw);
    assign h_eff  = (r_gh == '0) ? GW_W'(1) : ((r_gh > GW_W'(MAX_H)) ? GW_W'(MAX_H) : r_gh);
    assign cs_eff = (r_cs == '0) ? CS_W'(1) : ((r_cs > CS_W'(CS_MAX)) ? CS_W'(CS_MAX) : r_cs);

    assign lim_x   = (PIX_W+1)'(w_eff) * (PIX_W+1)'(cs_eff);
    assign lim_y   = (PIX_W+1)'(h_eff) * (PIX_W+1)'(cs_eff);
    assign pix_out = ({1'b0, r_px} >= lim_x) || ({1'b0, r_py} >= lim_y);

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign last_row = (GW_W'(r_y) + GW_W'(1)) == h_eff;
    assign nxt_row  = last_row ? r_row0 : mem_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GW_W'(64);
            r_gh <= GW_W'(64);
            r_cs <= CS_W'(10);
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_GRID_W:  r_gw <= pwdata[GW_W-1:0];
                REG_GRID_H:  r_gh <= pwdata[GW_W-1:0];
                REG_CELL_SZ: r_cs <= pwdata[CS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_W:  prdata = 32'(r_gw);
            REG_GRID_H:  prdata = 32'(r_gh);
            REG_CELL_SZ: prdata = 32'(r_cs);
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // row memory commands
    always_comb begin
        mem_cmd     = '0;
        mem_cmd.clr = in_acc && (t_req'(i_req_type) == REQ_CLEAR);
        unique case (r_state)
            S_TOG_RD:   mem_cmd.raddr = r_qy;
            S_TOG_WR: begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = r_qy;
                mem_cmd.wdata = mem_rdata ^ (MAX_W'(1) << r_qx);
            end
            S_RD_ADDR:  mem_cmd.raddr = r_cy;
            S_ST_LAST:  mem_cmd.raddr = ROW_AW'(h_eff - GW_W'(1));
            S_ST_FIRST: mem_cmd.raddr = '0;
            S_ST_RN:    mem_cmd.raddr = r_y + ROW_AW'(1);
            S_ST_WR: begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = r_y;
                mem_cmd.wdata = new_row;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req         = '0;
        div_req.divisor = cs_eff;
        if (r_state == S_TOG_CHK && !pix_out) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_px;
        end else if (r_state == S_DIV_X && div_done) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_py;
        end
    end

    tlgs_row_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mem_cmd),
        .o_rdata (mem_rdata)
    );

    tlgs_row_unit u_row (
        .i_prev  (r_prev),
        .i_cur   (r_cur),
        .i_next  (nxt_row),
        .i_width (w_eff),
        .o_row   (new_row)
    );

    tlgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_o_alive   <= 1'b0;
            r_o_ign     <= 1'b0;
            r_res_alive <= 1'b0;
            r_res_ign   <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_qx        <= '0;
            r_qy        <= '0;
            r_y         <= '0;
            r_prev      <= '0;
            r_cur       <= '0;
            r_row0      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_px        <= i_pixel_x;
                        r_py        <= i_pixel_y;
                        r_cx        <= i_cell_x;
                        r_cy        <= i_cell_y;
                        r_res_alive <= 1'b0;
                        r_res_ign   <= 1'b0;
                        unique case (t_req'(i_req_type))
                            REQ_TOGGLE: r_state <= S_TOG_CHK;
                            REQ_CLEAR:  r_state <= S_DONE;
                            REQ_STEP:   r_state <= S_ST_LAST;
                            REQ_READ:   r_state <= S_RD_ADDR;
                        endcase
                    end
                end
                S_TOG_CHK: begin
                    if (pix_out) begin
                        r_res_ign <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_DIV_X;
                    end
                end
                S_DIV_X: begin
                    if (div_done) begin
                        r_qx    <= div_quot[COL_AW-1:0];
                        r_state <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (div_done) begin
                        r_qy    <= div_quot[ROW_AW-1:0];
                        r_state <= S_TOG_RD;
                    end
                end
                S_TOG_RD:  r_state <= S_TOG_WR;
                S_TOG_WR:  r_state <= S_DONE;
                S_RD_ADDR: r_state <= S_RD_DATA;
                S_RD_DATA: begin
                    if (GW_W'(r_cx) < w_eff && GW_W'(r_cy) < h_eff) begin
                        r_res_alive <= mem_rdata[r_cx];
                    end else begin
                        r_res_ign <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_ST_LAST:  r_state <= S_ST_FIRST;
                S_ST_FIRST: begin
                    r_prev  <= mem_rdata;
                    r_state <= S_ST_HOLD;
                end
                S_ST_HOLD: begin
                    r_cur   <= mem_rdata;
                    r_row0  <= mem_rdata;
                    r_y     <= '0;
                    r_state <= S_ST_RN;
                end
                S_ST_RN: r_state <= S_ST_WR;
                S_ST_WR: begin
                    r_prev <= r_cur;
                    r_cur  <= nxt_row;
                    if (last_row) begin
                        r_state <= S_DONE;
                    end else begin
                        r_y     <= r_y + ROW_AW'(1);
                        r_state <= S_ST_RN;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_alive   <= r_res_alive;
                        r_o_ign     <= r_res_ign;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_o_alive;
    assign o_ignored    = r_o_ign;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request accepted but block not busy");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote pending transaction");

    a_toggle_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOG_WR) |-> (GW_W'(r_qx) < w_eff && GW_W'(r_qy) < h_eff))
        else $error("toggle outside grid in use");

    a_step_row_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ST_WR) |-> (GW_W'(r_y) < h_eff))
        else $error("step row beyond grid height");

endmodule

@@ design/tlgs_row_mem.sv @@
module tlgs_row_mem import tlgs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_cmd         i_cmd,
    output logic [MAX_W-1:0] o_rdata
);

    logic [MAX_W-1:0] r_mem [MAX_H];
    logic [MAX_H-1:0] r_vld;
    logic [MAX_W-1:0] r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    // rows not written since reset or the last clear read as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_cmd.raddr];
            if (i_cmd.clr) begin
                r_vld <= '0;
            end else if (i_cmd.we) begin
                r_vld[i_cmd.waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

@@ design/tlgs_row_unit.sv @@
module tlgs_row_unit import tlgs_pkg::*; (
    input  logic [MAX_W-1:0] i_prev,
    input  logic [MAX_W-1:0] i_cur,
    input  logic [MAX_W-1:0] i_next,
    input  logic [GW_W-1:0]  i_width,
    output logic [MAX_W-1:0] o_row
);

    logic [COL_AW-1:0]   last_col;
    logic [MAX_W-1:0]    rows  [3];
    logic [MAX_W-1:0]    l_nb  [3];
    logic [MAX_W-1:0]    r_nb  [3];
    logic [NB_CNT_W-1:0] nb_cnt [MAX_W];

    assign last_col = COL_AW'(i_width - GW_W'(1));
    assign rows[0]  = i_prev;
    assign rows[1]  = i_cur;
    assign rows[2]  = i_next;

    // wrapped left and right neighbors within the columns in use
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int x = 0; x < MAX_W; x++) begin
                if (x == 0) begin
                    l_nb[r][x] = rows[r][last_col];
                end else begin
                    l_nb[r][x] = rows[r][x-1];
                end
                if (COL_AW'(x) == last_col || x == MAX_W - 1) begin
                    r_nb[r][x] = rows[r][0];
                end else begin
                    r_nb[r][x] = rows[r][x+1];
                end
            end
        end
    end

    always_comb begin
        for (int x = 0; x < MAX_W; x++) begin
            nb_cnt[x] = NB_CNT_W'(l_nb[0][x]) + NB_CNT_W'(i_prev[x]) + NB_CNT_W'(r_nb[0][x])
                      + NB_CNT_W'(l_nb[1][x]) + NB_CNT_W'(r_nb[1][x])
                      + NB_CNT_W'(l_nb[2][x]) + NB_CNT_W'(i_next[x]) + NB_CNT_W'(r_nb[2][x]);
            if (GW_W'(x) < i_width) begin
                o_row[x] = (nb_cnt[x] == NB_CNT_W'(3))
                         || (i_cur[x] && nb_cnt[x] == NB_CNT_W'(2));
            end else begin
                o_row[x] = i_cur[x];
            end
        end
    end

endmodule

@@ design/tlgs_div.sv @@
module tlgs_div import tlgs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [PIX_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CS_W-1:0]      r_rem;
    logic [CS_W-1:0]      r_dsr;
    logic [PIX_W-1:0]     r_quo;
    logic [CS_W:0]        rem_sh;
    logic                 q_bit;
    logic [CS_W-1:0]      n_rem;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[PIX_W-1]};
        q_bit  = rem_sh >= {1'b0, r_dsr};
        if (q_bit) begin
            n_rem = CS_W'(rem_sh - {1'b0, r_dsr});
        end else begin
            n_rem = rem_sh[CS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_dsr  <= '0;
            r_quo  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PIX_W - 1);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[PIX_W-2:0], q_bit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

    a_no_start_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

@@ bench/toroidal_life_generation_step_top_test.sv @@
module toroidal_life_generation_step_top_test;
    import tlgs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * MAX_H + 8;

    localparam int REG_GRID_WIDTH  = 0;
    localparam int REG_GRID_HEIGHT = 1;
    localparam int REG_CELL_SIZE   = 2;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_req_type;
    logic [PIX_W-1:0]  i_pixel_x;
    logic [PIX_W-1:0]  i_pixel_y;
    logic [COL_AW-1:0] i_cell_x;
    logic [ROW_AW-1:0] i_cell_y;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_cell_alive;
    logic              o_ignored;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    typedef struct packed {
        logic alive;
        logic ignored;
    } life_result_t;

    life_result_t pending_results[$];

    bit          life_cells [MAX_H][MAX_W];
    int unsigned model_width;
    int unsigned model_height;
    int unsigned model_cell;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    toroidal_life_generation_step_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_alive (o_cell_alive),
        .o_ignored    (o_ignored),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int active_width();
        if (model_width == 0) return 1;
        if (model_width > MAX_W) return MAX_W;
        return model_width;
    endfunction

    function automatic int active_height();
        if (model_height == 0) return 1;
        if (model_height > MAX_H) return MAX_H;
        return model_height;
    endfunction

    function automatic int active_cell_size();
        if (model_cell == 0) return 1;
        if (model_cell > CS_MAX) return CS_MAX;
        return model_cell;
    endfunction

    // Applies one request to the life grid model and returns the result it yields.
    function automatic life_result_t apply_request(t_req req, int px, int py, int cx, int cy);
        life_result_t res;
        bit           next_gen [MAX_H][MAX_W];
        int           w;
        int           h;
        int           cs;
        int           live;
        w   = active_width();
        h   = active_height();
        cs  = active_cell_size();
        res = '0;
        case (req)
            REQ_TOGGLE: begin
                if (px >= w * cs || py >= h * cs)
                    res.ignored = 1'b1;
                else
                    life_cells[py / cs][px / cs] = ~life_cells[py / cs][px / cs];
            end
            REQ_CLEAR: begin
                for (int y = 0; y < MAX_H; y++)
                    for (int x = 0; x < MAX_W; x++)
                        life_cells[y][x] = 1'b0;
            end
            REQ_STEP: begin
                for (int y = 0; y < h; y++) begin
                    for (int x = 0; x < w; x++) begin
                        live = 0;
                        // repeated wrapped neighbors on tiny grids each count
                        for (int dy = 0; dy < 3; dy++)
                            for (int dx = 0; dx < 3; dx++)
                                if (!(dx == 1 && dy == 1))
                                    live += life_cells[(y + dy + h - 1) % h]
                                                      [(x + dx + w - 1) % w];
                        next_gen[y][x] = (live == 3) || (life_cells[y][x] && live == 2);
                    end
                end
                for (int y = 0; y < h; y++)
                    for (int x = 0; x < w; x++)
                        life_cells[y][x] = next_gen[y][x];
            end
            default: begin
                if (cx >= w || cy >= h)
                    res.ignored = 1'b1;
                else
                    res.alive = life_cells[cy][cx];
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        life_result_t want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(apply_request(t_req'(i_req_type),
                                                        int'(i_pixel_x), int'(i_pixel_y),
                                                        int'(i_cell_x), int'(i_cell_y)));
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected, expected none actual %0b/%0b",
                             $time, o_cell_alive, o_ignored);
                end else begin
                    want = pending_results.pop_front();
                    if (o_cell_alive !== want.alive) begin
                        error_count++;
                        $display("%0t: cell_alive expected %0b actual %0b",
                                 $time, want.alive, o_cell_alive);
                    end
                    if (o_ignored !== want.ignored) begin
                        error_count++;
                        $display("%0t: ignored expected %0b actual %0b",
                                 $time, want.ignored, o_ignored);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall = ($urandom_range(99) < stall_pct);

    task automatic send_request(t_req req, int px, int py, int cx, int cy);
        int gap;
        i_req_type = req;
        i_pixel_x  = px[PIX_W-1:0];
        i_pixel_y  = py[PIX_W-1:0];
        i_cell_x   = cx[COL_AW-1:0];
        i_cell_y   = cy[ROW_AW-1:0];
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic toggle_pixel(int px, int py);
        send_request(REQ_TOGGLE, px, py, $urandom_range(63), $urandom_range(63));
    endtask

    task automatic read_cell(int cx, int cy);
        send_request(REQ_READ, $urandom_range(4095), $urandom_range(4095), cx, cy);
    endtask

    task automatic step_grid();
        send_request(REQ_STEP, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(63), $urandom_range(63));
    endtask

    task automatic clear_grid();
        send_request(REQ_CLEAR, $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(63), $urandom_range(63));
    endtask

    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(int idx, int value);
        int mask;
        mask = (idx == REG_CELL_SIZE) ? 32'h3F : 32'h7F;
        wait_for_results();
        repeat (4) @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 4'(4 * idx);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_GRID_WIDTH:  model_width  = value & mask;
            REG_GRID_HEIGHT: model_height = value & mask;
            default:         model_cell   = value & mask;
        endcase
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask)) begin
            error_count++;
            $display("%0t: register %0d readback expected %0h actual %0h",
                     $time, idx, value & mask, prdata);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_geometry(int w, int h, int cs);
        write_register(REG_GRID_WIDTH, w);
        write_register(REG_GRID_HEIGHT, h);
        write_register(REG_CELL_SIZE, cs);
    endtask

    task automatic send_random_item();
        int w;
        int h;
        int cs;
        int pick;
        w    = active_width();
        h    = active_height();
        cs   = active_cell_size();
        pick = $urandom_range(99);
        if (pick < 40) begin
            if ($urandom_range(9) < 8)
                toggle_pixel($urandom_range(w * cs - 1), $urandom_range(h * cs - 1));
            else
                toggle_pixel($urandom_range(4095), $urandom_range(4095));
        end else if (pick < 75) begin
            if ($urandom_range(99) < 85)
                read_cell($urandom_range(w - 1), $urandom_range(h - 1));
            else
                read_cell($urandom_range(63), $urandom_range(63));
        end else if (pick < 93) begin
            step_grid();
        end else begin
            clear_grid();
        end
    endtask

    task automatic set_traffic(int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(63, 63);
    endtask

    task automatic test_toggle_edges();
        toggle_pixel(0, 0);
        toggle_pixel(639, 639);
        toggle_pixel(640, 0);
        toggle_pixel(0, 640);
        toggle_pixel(4095, 4095);
        read_cell(0, 0);
        read_cell(63, 63);
        toggle_pixel(9, 9);
        read_cell(0, 0);
    endtask

    task automatic test_blinker_wrap();
        clear_grid();
        toggle_pixel(635, 5);
        toggle_pixel(5, 5);
        toggle_pixel(15, 5);
        step_grid();
        read_cell(0, 63);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(63, 0);
        step_grid();
        read_cell(63, 0);
        clear_grid();
        read_cell(0, 0);
    endtask

    task automatic test_size_extremes();
        set_geometry(0, 0, 0);
        toggle_pixel(0, 0);
        toggle_pixel(1, 0);
        read_cell(0, 0);
        read_cell(1, 0);
        step_grid();
        read_cell(0, 0);
        set_geometry(127, 127, 63);
        toggle_pixel(2047, 2047);
        toggle_pixel(2048, 0);
        read_cell(63, 63);
        step_grid();
        read_cell(63, 63);
    endtask

    task automatic test_tiny_grids();
        for (int sz = 1; sz <= 3; sz++) begin
            set_geometry(sz, sz, 1);
            clear_grid();
            repeat (8) send_random_item();
            step_grid();
            for (int y = 0; y < sz; y++)
                for (int x = 0; x < sz; x++)
                    read_cell(x, y);
        end
    endtask

    task automatic test_outside_region();
        set_geometry(64, 64, 1);
        clear_grid();
        toggle_pixel(40, 40);
        toggle_pixel(41, 40);
        toggle_pixel(42, 40);
        set_geometry(8, 8, 1);
        toggle_pixel(40, 40);
        step_grid();
        set_geometry(64, 64, 1);
        read_cell(41, 39);
        read_cell(40, 40);
        step_grid();
        read_cell(41, 39);
        read_cell(40, 40);
    endtask

    task automatic test_random_phases();
        int widths  [4] = '{8, 5, 64, 17};
        int heights [4] = '{8, 7, 64, 3};
        int sizes   [4] = '{3, 1, 32, 63};
        int idles   [4] = '{0, 88, 0, 21};
        int stalls  [4] = '{0, 0, 88, 21};
        for (int p = 0; p < 4; p++) begin
            set_geometry(widths[p], heights[p], sizes[p]);
            set_traffic(idles[p], stalls[p]);
            clear_grid();
            for (int i = 0; i < 12; i++) begin
                if (i == 6) wait_for_results();
                send_random_item();
            end
        end
        set_traffic(0, 0);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_out_stall   = 1'b0;
        i_req_type    = REQ_TOGGLE;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_cell_x      = '0;
        i_cell_y      = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        model_width   = MAX_W;
        model_height  = MAX_H;
        model_cell    = 10;
        for (int y = 0; y < MAX_H; y++)
            for (int x = 0; x < MAX_W; x++)
                life_cells[y][x] = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_toggle_edges();
        test_blinker_wrap();
        test_size_extremes();
        test_tiny_grids();
        test_outside_region();
        test_random_phases();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d results expected, actual none", $time, pending_results.size());
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
